// ----- src/tksi_pkg.sv -----
// shared types, constants and the name normalisation function of the top-k table
`default_nettype none

package tksi_pkg;

    localparam int TABLE_ENTRIES = 10;
    localparam int NAME_CHARS    = 8;

    localparam int NAME_W  = 64;
    localparam int SCORE_W = 32;
    localparam int TIME_W  = 32;
    localparam int PHASE_W = 8;
    localparam int RIDX_W  = 6;
    localparam int POS_W   = 6;
    localparam int OCNT_W  = 7;

    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7a;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_DUP      = 3'd2,
        ST_LOW      = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_RANGE    = 3'd5
    } t_status;

    typedef struct packed {
        logic                      action;
        logic [NAME_W-1:0]         name_bytes;
        logic signed [SCORE_W-1:0] score;
        logic [TIME_W-1:0]         time_word;
        logic [PHASE_W-1:0]        phase;
        logic [RIDX_W-1:0]         read_index;
    } t_in_req;

    typedef struct packed {
        t_status                   status;
        logic [POS_W-1:0]          position;
        logic [OCNT_W-1:0]         count;
        logic [NAME_W-1:0]         entry_name;
        logic signed [SCORE_W-1:0] entry_score;
        logic [TIME_W-1:0]         entry_time;
        logic [PHASE_W-1:0]        entry_phase;
    } t_out_rsp;

    typedef struct packed {
        logic [NAME_W-1:0]         name;
        logic signed [SCORE_W-1:0] score;
        logic [TIME_W-1:0]         time_word;
        logic [PHASE_W-1:0]        phase;
    } t_entry;

    // cut at first zero byte or NAME_CHARS, upper-case a..z
    function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              stop;
        logic [7:0]        c;
        res  = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            c = raw[8*i +: 8];
            if (i >= NAME_CHARS || c == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                    c = c - CASE_OFFSET;
                end
                res[8*i +: 8] = c;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/tksi_ram.sv -----
// entry store: one write port, one registered read port
`default_nettype none

module tksi_ram #(
    parameter int  DEPTH = tksi_pkg::TABLE_ENTRIES,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_wr_en,
    input  wire logic [AW-1:0]           i_wr_addr,
    input  wire tksi_pkg::t_entry        i_wr_data,
    input  wire logic                    i_rd_en,
    input  wire logic [AW-1:0]           i_rd_addr,
    output tksi_pkg::t_entry             o_rd_data
);

    tksi_pkg::t_entry r_mem [DEPTH];
    tksi_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/top_k_sorted_insert_unique.sv -----
// top-k table sorted by descending score with unique upper-case names
// path: a read goes through S_READ; an out-of-range read or an empty name goes straight
//   to S_RESULT; an insert runs S_SCAN and S_DECIDE, a rejected one then ends, an accepted
//   one runs S_SHIFT when entries move, then S_WRITE; all end in S_RESULT and the output register
// throughput: one request at a time; the scan and the shift walk the store one entry a cycle
// reset: synchronous active-low reset empties the table; entry contents are not cleared
`default_nettype none

module top_k_sorted_insert_unique #(
    parameter int TABLE_ENTRIES = tksi_pkg::TABLE_ENTRIES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tksi_pkg::t_in_req  i_in_req,
    // response channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tksi_pkg::t_out_rsp      o_out_rsp
);

    // index width into the store and width of the entry count
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
    localparam int NAME_W_L = tksi_pkg::NAME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,     // walk all filled entries: duplicate name and first lower score
        S_DECIDE,   // pick status, start the shift or the write
        S_SHIFT,    // move entries pos..newc-2 one place down, highest first
        S_WRITE,    // drop the new entry into its slot
        S_READ,     // read data comes back from the store
        S_RESULT    // hand the response to the output register
    } t_state;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [CNT_W-1:0]              r_newc, n_newc;
    logic [CNT_W-1:0]              r_ridx, n_ridx;   // next address to read
    logic [IDX_W-1:0]              r_cidx, n_cidx;   // address of data coming back
    logic                          r_pend, n_pend;   // read issued last cycle
    logic                          r_more, n_more;   // shift still has sources to read
    logic                          r_dup, n_dup;
    logic                          r_found, n_found;
    logic [CNT_W-1:0]              r_pos, n_pos;
    tksi_pkg::t_entry              r_new, n_new;     // normalised request being inserted
    tksi_pkg::t_out_rsp            r_rsp, n_rsp;     // response waiting for the output register
    tksi_pkg::t_out_rsp            r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    // entry store port signals
    logic                          ram_wr_en;
    logic [IDX_W-1:0]              ram_wr_addr;
    tksi_pkg::t_entry              ram_wr_data;
    logic                          ram_rd_en;
    logic [IDX_W-1:0]              ram_rd_addr;
    tksi_pkg::t_entry              ram_rd_data;

    // decision values
    logic [CNT_W-1:0]              dec_pos;
    logic                          dec_full;
    logic [CNT_W-1:0]              dec_newc;
    logic [NAME_W_L-1:0]           in_name;

    tksi_ram #(
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign in_name  = tksi_pkg::normalize_name(i_in_req.name_bytes);
    // no lower score found means the new entry goes at the end
    assign dec_pos  = r_found ? r_pos : r_count;
    assign dec_full = (r_count == FULL_CNT);
    assign dec_newc = dec_full ? r_count : r_count + CNT_W'(1);

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_newc      = r_newc;
        n_ridx      = r_ridx;
        n_cidx      = r_cidx;
        n_pend      = 1'b0;
        n_more      = r_more;
        n_dup       = r_dup;
        n_found     = r_found;
        n_pos       = r_pos;
        n_new       = r_new;
        n_rsp       = r_rsp;
        n_out       = r_out;
        // output register empties when the downstream side takes it
        n_out_valid = r_out_valid & i_out_stall;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = r_new;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rsp          = '0;
                    n_rsp.count    = tksi_pkg::OCNT_W'(r_count);
                    if (i_in_req.action == tksi_pkg::ACT_READ) begin
                        if ({1'b0, i_in_req.read_index} < tksi_pkg::OCNT_W'(r_count)) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = i_in_req.read_index[IDX_W-1:0];
                            n_state     = S_READ;
                        end else begin
                            n_rsp.status = tksi_pkg::ST_RANGE;
                            n_state      = S_RESULT;
                        end
                    end else begin
                        n_new.name      = in_name;
                        n_new.score     = i_in_req.score;
                        n_new.time_word = i_in_req.time_word;
                        n_new.phase     = i_in_req.phase;
                        n_ridx          = '0;
                        n_dup           = 1'b0;
                        n_found         = 1'b0;
                        if (in_name[7:0] == 8'd0) begin
                            n_rsp.status = tksi_pkg::ST_EMPTY;
                            n_state      = S_RESULT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // one read issued per cycle, compared the cycle after
                if (r_ridx < r_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_ridx[IDX_W-1:0];
                    n_cidx      = r_ridx[IDX_W-1:0];
                    n_pend      = 1'b1;
                    n_ridx      = r_ridx + CNT_W'(1);
                end
                if (r_pend) begin
                    if (ram_rd_data.name == r_new.name) begin
                        n_dup = 1'b1;
                    end
                    if (!r_found && (r_new.score > ram_rd_data.score)) begin
                        n_found = 1'b1;
                        n_pos   = CNT_W'(r_cidx);
                    end
                end
                if (!r_pend && (r_ridx >= r_count)) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_rsp       = '0;
                n_rsp.count = tksi_pkg::OCNT_W'(r_count);
                priority if (r_dup) begin
                    n_rsp.status = tksi_pkg::ST_DUP;
                    n_state      = S_RESULT;
                end else if (dec_full && !r_found) begin
                    // full table and no entry with a lower score
                    n_rsp.status = tksi_pkg::ST_LOW;
                    n_state      = S_RESULT;
                end else begin
                    n_pos  = dec_pos;
                    n_newc = dec_newc;
                    if ((dec_newc - CNT_W'(1)) > dec_pos) begin
                        n_ridx  = dec_newc - CNT_W'(2);
                        n_more  = 1'b1;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end

            S_SHIFT: begin
                // read source j while writing the previous source to its next slot
                if (r_more) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_ridx[IDX_W-1:0];
                    n_cidx      = r_ridx[IDX_W-1:0];
                    n_pend      = 1'b1;
                    if (r_ridx == r_pos) begin
                        n_more = 1'b0;
                    end else begin
                        n_ridx = r_ridx - CNT_W'(1);
                    end
                end
                if (r_pend) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_cidx + IDX_W'(1);
                    ram_wr_data = ram_rd_data;
                end
                if (!r_more && !r_pend) begin
                    n_state = S_WRITE;
                end
            end

            S_WRITE: begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = r_pos[IDX_W-1:0];
                ram_wr_data    = r_new;
                n_count        = r_newc;
                n_rsp          = '0;
                n_rsp.status   = tksi_pkg::ST_INSERTED;
                n_rsp.position = tksi_pkg::POS_W'(r_pos);
                n_rsp.count    = tksi_pkg::OCNT_W'(r_newc);
                n_state        = S_RESULT;
            end

            S_READ: begin
                n_rsp.status      = tksi_pkg::ST_READ_OK;
                n_rsp.entry_name  = ram_rd_data.name;
                n_rsp.entry_score = ram_rd_data.score;
                n_rsp.entry_time  = ram_rd_data.time_word;
                n_rsp.entry_phase = ram_rd_data.phase;
                n_state           = S_RESULT;
            end

            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_rsp;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
        end
        // payload and per-request working registers
        r_newc  <= n_newc;
        r_ridx  <= n_ridx;
        r_cidx  <= n_cidx;
        r_dup   <= n_dup;
        r_found <= n_found;
        r_pos   <= n_pos;
        r_new   <= n_new;
        r_rsp   <= n_rsp;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // table never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above capacity");

    // the store is only written while shifting or placing a new entry
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (r_state == S_SHIFT || r_state == S_WRITE))
        else $error("store written outside insert");

    // an insert lands inside the valid part of the table
    a_insert_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status == tksi_pkg::ST_INSERTED)
        |-> (o_out_rsp.position < o_out_rsp.count))
        else $error("insert position beyond count");

    // a new response only comes from the result state
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !r_out_valid) |-> (r_state == S_RESULT))
        else $error("response loaded outside result state");

    // the count changes only when an entry is written in
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_count != r_count) |-> (r_state == S_WRITE))
        else $error("count changed without insert");

endmodule

`default_nettype wire

// ----- test/top_k_sorted_insert_unique_test.sv -----
// self-checking testbench of the top-k sorted insertion table with unique names
`timescale 1ns / 100ps

module top_k_sorted_insert_unique_test;

    // run shape
    localparam int RANDOM_ITEMS = 1425;
    localparam int PAUSE_AT     = 700;    // sender waits here until the table is quiet
    localparam int QUIET_FIRST  = 950;    // no sender gaps in this stretch
    localparam int QUIET_LAST   = 1150;
    localparam int HOLD_AFTER   = 400;    // responses seen before the long receiver hold
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * tksi_pkg::TABLE_ENTRIES + 20;

    localparam logic [7:0] UPPER_A = tksi_pkg::CH_LOWER_A - tksi_pkg::CASE_OFFSET;
    localparam logic [7:0] UPPER_Z = tksi_pkg::CH_LOWER_Z - tksi_pkg::CASE_OFFSET;

    typedef struct {
        tksi_pkg::t_in_req  req;
        bit                 typed;      // expected response written in the row
        tksi_pkg::t_out_rsp want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    tksi_pkg::t_in_req  i_in_req;
    logic               o_out_valid;
    logic               i_out_stall;
    tksi_pkg::t_out_rsp o_out_rsp;

    // own copy of the table, kept in step with accepted requests
    tksi_pkg::t_entry   board [tksi_pkg::TABLE_ENTRIES];
    int                 board_count;

    tksi_pkg::t_out_rsp pending_rsp [$];
    int                 pending_tag [$];
    t_stim_row          stim_rows [$];
    int                 mismatches   = 0;
    int                 results_seen = 0;

    top_k_sorted_insert_unique u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always #1 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // expected response of one request; updates the table copy as the block would
    function automatic tksi_pkg::t_out_rsp rank_update(input tksi_pkg::t_in_req req);
        tksi_pkg::t_out_rsp          rsp;
        logic [tksi_pkg::NAME_W-1:0] nm;
        logic [7:0]                  c;
        bit                          ended;
        bit                          dup;
        int                          pos;
        int                          newc;
        rsp = '0;
        if (req.action == tksi_pkg::ACT_READ) begin
            if (req.read_index < board_count) begin
                rsp.status      = tksi_pkg::ST_READ_OK;
                rsp.entry_name  = board[req.read_index].name;
                rsp.entry_score = board[req.read_index].score;
                rsp.entry_time  = board[req.read_index].time_word;
                rsp.entry_phase = board[req.read_index].phase;
            end else begin
                rsp.status = tksi_pkg::ST_RANGE;
            end
        end else begin
            // canonical name: stops at the first zero byte, letters folded to upper case
            nm    = '0;
            ended = 1'b0;
            for (int i = 0; i < tksi_pkg::NAME_CHARS; i++) begin
                c     = req.name_bytes[8*i +: 8];
                ended = ended || (c == 8'h00);
                if (!ended) begin
                    nm[8*i +: 8] = (c >= tksi_pkg::CH_LOWER_A && c <= tksi_pkg::CH_LOWER_Z)
                                   ? c - tksi_pkg::CASE_OFFSET : c;
                end
            end
            dup = 1'b0;
            for (int i = 0; i < board_count; i++) begin
                if (board[i].name == nm) begin
                    dup = 1'b1;
                end
            end
            if (nm[7:0] == 8'h00) begin
                rsp.status = tksi_pkg::ST_EMPTY;
            end else if (dup) begin
                rsp.status = tksi_pkg::ST_DUP;
            end else if (board_count >= tksi_pkg::TABLE_ENTRIES &&
                         !($signed(req.score) >
                           $signed(board[tksi_pkg::TABLE_ENTRIES-1].score))) begin
                rsp.status = tksi_pkg::ST_LOW;
            end else begin
                // first slot whose score is beaten; equal scores stay ahead
                pos = board_count;
                for (int i = board_count - 1; i >= 0; i--) begin
                    if ($signed(req.score) > $signed(board[i].score)) begin
                        pos = i;
                    end
                end
                newc = (board_count < tksi_pkg::TABLE_ENTRIES) ? board_count + 1
                                                               : tksi_pkg::TABLE_ENTRIES;
                for (int i = newc - 1; i > pos; i--) begin
                    board[i] = board[i-1];
                end
                board[pos].name      = nm;
                board[pos].score     = req.score;
                board[pos].time_word = req.time_word;
                board[pos].phase     = req.phase;
                board_count          = newc;
                rsp.status           = tksi_pkg::ST_INSERTED;
                rsp.position         = pos[tksi_pkg::POS_W-1:0];
            end
        end
        rsp.count = board_count[tksi_pkg::OCNT_W-1:0];
        return rsp;
    endfunction

    // first character goes to the low byte
    function automatic logic [tksi_pkg::NAME_W-1:0] pack_name(input string s);
        logic [tksi_pkg::NAME_W-1:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 8; i++) begin
            r[8*i +: 8] = s[i];
        end
        return r;
    endfunction

    function automatic tksi_pkg::t_in_req insert_req(
        input logic [tksi_pkg::NAME_W-1:0]  nm,
        input logic [tksi_pkg::SCORE_W-1:0] sc,
        input logic [tksi_pkg::TIME_W-1:0]  tw,
        input logic [tksi_pkg::PHASE_W-1:0] ph);
        tksi_pkg::t_in_req req;
        req.action     = tksi_pkg::ACT_INSERT;
        req.name_bytes = nm;
        req.score      = sc;
        req.time_word  = tw;
        req.phase      = ph;
        req.read_index = 6'($urandom);     // ignored on insert
        return req;
    endfunction

    function automatic tksi_pkg::t_in_req read_req(input logic [tksi_pkg::RIDX_W-1:0] idx);
        tksi_pkg::t_in_req req;
        req.action     = tksi_pkg::ACT_READ;
        req.name_bytes = {$urandom, $urandom};    // ignored on read
        req.score      = $urandom;
        req.time_word  = $urandom;
        req.phase      = 8'($urandom);
        req.read_index = idx;
        return req;
    endfunction

    function automatic tksi_pkg::t_out_rsp fixed_rsp(input tksi_pkg::t_status st, input int cnt);
        tksi_pkg::t_out_rsp rsp;
        rsp        = '0;
        rsp.status = st;
        rsp.count  = cnt[tksi_pkg::OCNT_W-1:0];
        return rsp;
    endfunction

    task automatic add_row(input tksi_pkg::t_in_req req, input bit typed,
                           input tksi_pkg::t_out_rsp want);
        t_stim_row row;
        row.req   = req;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // random request, mostly well formed against the current table contents
    function automatic tksi_pkg::t_in_req random_request();
        tksi_pkg::t_in_req req;
        tksi_pkg::t_entry  pick;
        logic [7:0]        c;
        bit                ended;
        int                kind;
        int                len;
        int                sel;
        req  = insert_req({$urandom, $urandom}, $urandom, $urandom, 8'($urandom));
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            req = read_req(6'($urandom));
            if ($urandom_range(0, 9) < 7) begin
                req.read_index = 6'($urandom_range(0, board_count));
            end
        end else if (kind < 45 && board_count > 0) begin
            // name already present, random case, junk past the terminator
            pick  = board[$urandom_range(0, board_count - 1)];
            ended = 1'b0;
            for (int k = 0; k < 8; k++) begin
                c = pick.name[8*k +: 8];
                if (ended) begin
                    c = 8'($urandom);
                end else if (c == 8'h00) begin
                    ended = 1'b1;
                end else if (c >= UPPER_A && c <= UPPER_Z && $urandom_range(0, 1)) begin
                    c = c + tksi_pkg::CASE_OFFSET;
                end
                req.name_bytes[8*k +: 8] = c;
            end
        end else if (kind < 85) begin
            // fresh name of random length, mostly letters of either case
            len = $urandom_range(1, 8);
            for (int k = 0; k < 8; k++) begin
                if (k < len) begin
                    if ($urandom_range(0, 9) == 0) begin
                        c = 8'($urandom_range(1, 255));
                    end else begin
                        c = tksi_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
                        if ($urandom_range(0, 1)) begin
                            c = c - tksi_pkg::CASE_OFFSET;
                        end
                    end
                end else if (k == len) begin
                    c = 8'h00;
                end else begin
                    c = 8'($urandom);
                end
                req.name_bytes[8*k +: 8] = c;
            end
            // scores around the last entry and ties keep the full table busy
            sel = $urandom_range(0, 9);
            if (sel < 4 && board_count > 0) begin
                req.score = board[board_count-1].score + $urandom_range(0, 4) - 2;
            end else if (sel < 6 && board_count > 0) begin
                req.score = board[$urandom_range(0, board_count - 1)].score;
            end
        end else if (kind < 92) begin
            req.name_bytes[7:0] = 8'h00;
        end
        return req;
    endfunction

    // response side: compare against the oldest expectation
    task automatic check_response(input tksi_pkg::t_out_rsp got);
        tksi_pkg::t_out_rsp want;
        int                 tag;
        if (pending_rsp.size() == 0) begin
            flag_mismatch($sformatf("response with nothing expected, status %0d", got.status));
        end else begin
            want = pending_rsp.pop_front();
            tag  = pending_tag.pop_front();
            if (got.status !== want.status)
                flag_mismatch($sformatf("request %0d status %0d, expected %0d",
                                        tag, got.status, want.status));
            if (got.position !== want.position)
                flag_mismatch($sformatf("request %0d position %0d, expected %0d",
                                        tag, got.position, want.position));
            if (got.count !== want.count)
                flag_mismatch($sformatf("request %0d count %0d, expected %0d",
                                        tag, got.count, want.count));
            if (got.entry_name !== want.entry_name)
                flag_mismatch($sformatf("request %0d name %h, expected %h",
                                        tag, got.entry_name, want.entry_name));
            if (got.entry_score !== want.entry_score)
                flag_mismatch($sformatf("request %0d score %0d, expected %0d",
                                        tag, got.entry_score, want.entry_score));
            if (got.entry_time !== want.entry_time)
                flag_mismatch($sformatf("request %0d time %h, expected %h",
                                        tag, got.entry_time, want.entry_time));
            if (got.entry_phase !== want.entry_phase)
                flag_mismatch($sformatf("request %0d phase %h, expected %h",
                                        tag, got.entry_phase, want.entry_phase));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            check_response(o_out_rsp);
            results_seen++;
        end
    end

    // receiver: stall pattern changes mode now and then, one long hold-off
    initial begin
        int mode;
        int mode_left;
        bit held;
        mode        = 0;
        mode_left   = 0;
        held        = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                // long hold: the block fills up and must stall its request side
                held        = 1'b1;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                0: begin
                    i_out_stall = 1'b0;
                end
                1: begin
                    i_out_stall = ($urandom_range(0, 9) < 3);
                end
                2: begin
                    i_out_stall = ($urandom_range(0, 9) < 7);
                end
                default: begin
                    i_out_stall = ~i_out_stall;
                end
            endcase
        end
    end

    // sender: directed table first, then random requests in bursts
    initial begin
        tksi_pkg::t_in_req  req;
        tksi_pkg::t_out_rsp want;
        int                 total;
        int                 burst_left;
        int                 gap;
        bit                 typed;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        board_count = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: reads out of range, empty names rejected
        add_row(read_req(6'd0), 1, fixed_rsp(tksi_pkg::ST_RANGE, 0));
        add_row(read_req(6'd63), 1, fixed_rsp(tksi_pkg::ST_RANGE, 0));
        add_row(insert_req(64'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF), 1,
                fixed_rsp(tksi_pkg::ST_EMPTY, 0));
        // first byte zero with junk behind it is still empty
        add_row(insert_req(64'hFFFF_FFFF_FFFF_FF00, 32'h0, 32'h0, 8'h0), 1,
                fixed_rsp(tksi_pkg::ST_EMPTY, 0));
        // lower case name at top score and widest time and phase
        add_row(insert_req(pack_name("alice"), 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF), 0, '0);
        // duplicate in other case
        add_row(insert_req(pack_name("ALICE"), 32'h0000_0001, 32'h1234_5678, 8'h12), 0, '0);
        // bytes past the terminator do not count, then duplicate in mixed case
        add_row(insert_req(64'h007A_7978_0062_6F62, -32'sd5, 32'h0, 8'h0), 0, '0);
        add_row(insert_req(pack_name("Bob"), 32'sd99, 32'h0, 8'h0), 0, '0);
        // bytes of 0x80 and above kept, lowest score, zero time and phase
        add_row(insert_req(64'hF8F9_FAFB_FCFD_FEFF, 32'h8000_0000, 32'h0, 8'h0), 0, '0);
        // full eight bytes with neighbours of the letter ranges
        add_row(insert_req(64'h5A41_5B40_607B_7A61, 32'h0, 32'hA5A5_5A5A, 8'h5A), 0, '0);
        // equal scores queue up behind each other
        add_row(insert_req(pack_name("tie1"), 32'h0, 32'h1, 8'h1), 0, '0);
        add_row(insert_req(pack_name("tie2"), 32'h0, 32'h2, 8'h2), 0, '0);
        add_row(read_req(6'd0), 0, '0);
        add_row(read_req(6'd5), 0, '0);
        add_row(read_req(6'd6), 1, fixed_rsp(tksi_pkg::ST_RANGE, 6));
        // fill the table
        add_row(insert_req(pack_name("c1"), 32'sd100, 32'h3, 8'h3), 0, '0);
        add_row(insert_req(pack_name("c2"), -32'sd100, 32'h4, 8'h4), 0, '0);
        add_row(insert_req(pack_name("c3"), 32'sd50, 32'h5, 8'h5), 0, '0);
        add_row(insert_req(pack_name("c4"), 32'sd7, 32'h6, 8'h6), 0, '0);
        // full: score equal to the last entry is too low, a better one drops the last
        add_row(insert_req(pack_name("low"), 32'h8000_0000, 32'h7, 8'h7), 0, '0);
        add_row(insert_req(pack_name("high"), 32'sd1, 32'h8, 8'h8), 0, '0);
        add_row(read_req(6'd9), 0, '0);
        add_row(read_req(6'd10), 1, fixed_rsp(tksi_pkg::ST_RANGE, 10));
        add_row(insert_req(pack_name("tie3"), 32'h0, 32'h9, 8'h9), 0, '0);
        add_row(insert_req(pack_name("zzzzzzzz"), 32'hFFFF_FFFF, 32'hA, 8'hA), 0, '0);

        total      = stim_rows.size() + RANDOM_ITEMS;
        burst_left = 0;
        for (int n = 0; n < total; n++) begin
            if (n == PAUSE_AT) begin
                // let every outstanding response come back before going on
                @(negedge i_clk);
                i_in_valid = 1'b0;
                while (pending_rsp.size() != 0) @(posedge i_clk);
            end
            if (n < stim_rows.size()) begin
                req   = stim_rows[n].req;
                typed = stim_rows[n].typed;
                want  = stim_rows[n].want;
            end else begin
                req   = random_request();
                typed = 1'b0;
                want  = '0;
            end
            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                if (n < QUIET_FIRST || n > QUIET_LAST) begin
                    gap = $urandom_range(0, 12);
                end
            end
            burst_left--;
            @(negedge i_clk);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_valid = 1'b1;
            i_in_req   = req;
            do @(posedge i_clk); while (o_in_stall !== 1'b0);
            // accepted at this edge: predictor runs on every request to stay in step
            if (typed) begin
                void'(rank_update(req));
                pending_rsp.push_back(want);
            end else begin
                pending_rsp.push_back(rank_update(req));
            end
            pending_tag.push_back(n);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** top_k_sorted_insert_unique: PASSED **");
        end else begin
            $display("** top_k_sorted_insert_unique: FAILED **");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #1000000;
        $display("** top_k_sorted_insert_unique: FAILED **");
        $finish;
    end

endmodule

// ----- top_k_sorted_insert_unique.f -----
src/tksi_pkg.sv
src/tksi_ram.sv
src/top_k_sorted_insert_unique.sv
test/top_k_sorted_insert_unique_test.sv
